// ----- hdl/epc_pkg.sv -----
// Shared types, constants and lookup tables for the encoder position controller.
package epc_pkg;

    localparam int COUNTS_PER_TURN = 160;
    localparam int ADC_FULL        = 255;
    localparam int DUTY_START      = 25;
    localparam int DUTY_MAX        = 1023;
    localparam int DUTY_SPAN       = DUTY_MAX - DUTY_START;

    localparam int POS_W   = 8;
    localparam int DUTY_W  = 10;
    localparam int GAIN_W  = 4;
    localparam int BAND_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd1;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd4;
    localparam logic [BAND_W-1:0] BAND_RESET = 8'd3;

    typedef struct packed {
        logic       operation;
        logic       clockwise;
        logic [7:0] adc_sample;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [7:0]        position_display;
        logic [DUTY_W-1:0] drive_cw;
        logic [DUTY_W-1:0] drive_ccw;
        logic              direction;
    } t_out_item;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic              dir;
        logic [DUTY_W-1:0] cw;
        logic [DUTY_W-1:0] ccw;
    } t_state;

    typedef logic [255:0][7:0]        t_tab8;
    typedef logic [255:0][DUTY_W-1:0] t_tab10;

    // adc -> reference count
    function automatic t_tab8 build_ref_tab();
        t_tab8 tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = 8'((i * COUNTS_PER_TURN) / ADC_FULL);
        end
        return tab;
    endfunction

    // position -> 0..255 display value
    function automatic t_tab8 build_disp_tab();
        t_tab8 tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = 8'((i * ADC_FULL) / COUNTS_PER_TURN);
        end
        return tab;
    endfunction

    // drive magnitude below one turn -> duty above start level
    function automatic t_tab10 build_duty_tab();
        t_tab10 tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = DUTY_W'((i * DUTY_SPAN) / COUNTS_PER_TURN);
        end
        return tab;
    endfunction

    localparam t_tab8  REF_TAB  = build_ref_tab();
    localparam t_tab8  DISP_TAB = build_disp_tab();
    localparam t_tab10 DUTY_TAB = build_duty_tab();

endpackage

// ----- hdl/encoder_position_p_controller_top.sv -----
// Top level of the encoder position proportional controller with deadband.
//
//  channel | dir | handshake                      | payload
//  in      | in  | i_in_valid / o_in_ready        | i_in  (t_in_item)
//  out     | out | o_out_valid / i_out_ready      | o_out (t_out_item)
//  cfg     | in  | i_cfg_we                       | i_cfg_index, i_cfg_data
//
// One item per cycle unless the output stalls; the result is registered.
// The position and duty state is updated as an item moves from the input
// register to the result register, so each item sees all earlier ones.
// A stalled output holds the result register; the input register backs up behind it.
// Reset clears position, direction and duties, sets gain 4 and deadband 3.
module encoder_position_p_controller_top
    import epc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic              r_in_vld;
    t_in_item          r_in;
    logic              r_out_vld;
    t_out_item         r_out;
    t_state            r_state;
    t_state            n_state;
    t_out_item         n_out;
    logic [GAIN_W-1:0] r_gain;
    logic [BAND_W-1:0] r_deadband;
    logic              advance;

    assign advance     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || advance;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    epc_core u_core (
        .i_state    (r_state),
        .i_item     (r_in),
        .i_gain     (r_gain),
        .i_deadband (r_deadband),
        .o_state    (n_state),
        .o_result   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= GAIN_RESET;
            r_deadband <= BAND_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAIN:     r_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_DEADBAND: r_deadband <= i_cfg_data[BAND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pos <= POS_W'(COUNTS_PER_TURN))
        else $error("position left its range");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state.cw != '0 && r_state.ccw != '0))
        else $error("both duties driven");

    a_duty_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.cw == '0 || r_state.cw >= DUTY_W'(DUTY_START)) &&
        (r_state.ccw == '0 || r_state.ccw >= DUTY_W'(DUTY_START)))
        else $error("duty below start level");

    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_vld && r_out.position == r_state.pos)
        else $error("result register missed a beat");

endmodule

// ----- hdl/epc_core.sv -----
// Single-pass next-state and result logic for one item.
module epc_core
    import epc_pkg::*;
(
    input  t_state            i_state,
    input  t_in_item          i_item,
    input  logic [GAIN_W-1:0] i_gain,
    input  logic [BAND_W-1:0] i_deadband,
    output t_state            o_state,
    output t_out_item         o_result
);

    localparam logic [POS_W-1:0]  POS_TOP  = POS_W'(COUNTS_PER_TURN);
    localparam logic [13:0]       MAG_TOP  = 14'(COUNTS_PER_TURN);
    localparam logic [DUTY_W-1:0] DUTY_LO  = DUTY_W'(DUTY_START);
    localparam logic [DUTY_W-1:0] DUTY_HI  = DUTY_W'(DUTY_MAX);

    logic [7:0]         ref_cnt;
    logic signed [9:0]  err;
    logic signed [14:0] drive;
    logic signed [14:0] band;
    logic [13:0]        mag;
    logic [DUTY_W-1:0]  duty;
    logic               drive_pos;
    logic               drive_neg;

    assign ref_cnt   = REF_TAB[i_item.adc_sample];
    assign err       = $signed({2'b00, ref_cnt}) - $signed({2'b00, i_state.pos});
    assign drive     = $signed({11'b0, i_gain}) * $signed({{5{err[9]}}, err});
    assign band      = $signed({7'b0, i_deadband});
    assign drive_pos = drive > band;
    assign drive_neg = drive < -band;
    assign mag       = drive[14] ? 14'(-drive) : drive[13:0];
    assign duty      = (mag >= MAG_TOP) ? DUTY_HI : DUTY_LO + DUTY_TAB[mag[7:0]];

    always_comb begin
        o_state = i_state;
        case (i_item.operation)
            OP_TICK: begin
                o_state.dir = i_item.clockwise;
                if (i_item.clockwise) begin
                    o_state.pos = (i_state.pos >= POS_TOP) ? '0 : i_state.pos + 1'b1;
                end else begin
                    o_state.pos = (i_state.pos == '0 || i_state.pos > POS_TOP) ?
                                  POS_TOP : i_state.pos - 1'b1;
                end
            end
            OP_SAMPLE: begin
                o_state.cw  = drive_pos ? duty : '0;
                o_state.ccw = (!drive_pos && drive_neg) ? duty : '0;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

    assign o_result.position         = o_state.pos;
    assign o_result.position_display = DISP_TAB[o_state.pos];
    assign o_result.drive_cw         = o_state.cw;
    assign o_result.drive_ccw        = o_state.ccw;
    assign o_result.direction        = o_state.dir;

endmodule
